// ===== hw/rtl/mctc_pkg.sv =====
// Shared types and constants for the microwave cook timer controller.
// Holds item/result structs, mode and recipe codes, keypad codes.
// No dependencies.
`default_nettype none

package mctc_pkg;

    // Action kinds carried on s_tuser
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_KEY  = 2'd1;
    localparam logic [1:0] ACT_POLL = 2'd2;

    // Keypad characters
    localparam logic [7:0] KEY_0 = 8'h30;
    localparam logic [7:0] KEY_1 = 8'h31;
    localparam logic [7:0] KEY_9 = 8'h39;
    localparam logic [7:0] KEY_A = 8'h41;
    localparam logic [7:0] KEY_B = 8'h42;
    localparam logic [7:0] KEY_C = 8'h43;
    localparam logic [7:0] KEY_D = 8'h44;

    // Mode codes as seen on the result beat
    localparam logic [2:0] MODE_CODE_MENU   = 3'd0;
    localparam logic [2:0] MODE_CODE_WEIGHT = 3'd1;
    localparam logic [2:0] MODE_CODE_TIME   = 3'd2;
    localparam logic [2:0] MODE_CODE_READY  = 3'd3;
    localparam logic [2:0] MODE_CODE_COOK   = 3'd4;
    localparam logic [2:0] MODE_CODE_PAUSE  = 3'd5;

    // Entry error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_WEIGHT = 2'd1;
    localparam logic [1:0] ERR_RANGE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BEEF    = 2'd0;
    localparam logic [1:0] CFG_CHICKEN = 2'd1;
    localparam logic [1:0] CFG_POPCORN = 2'd2;

    // Configuration reset values
    localparam logic [5:0]  BEEF_RATE_RST    = 6'd30;
    localparam logic [5:0]  CHICKEN_RATE_RST = 6'd12;
    localparam logic [10:0] POPCORN_RST      = 11'd60;

    // Reciprocal of 60 scaled by 2^17 and rounded up, exact for totals below 2048
    localparam logic [11:0] RECIP_60 = 12'd2185;

    typedef enum logic [1:0] {
        RECIPE_POPCORN = 2'd0,
        RECIPE_BEEF    = 2'd1,
        RECIPE_CHICKEN = 2'd2,
        RECIPE_MANUAL  = 2'd3
    } recipe_t;

    typedef enum logic [5:0] {
        MODE_MENU   = 6'b000001,
        MODE_WEIGHT = 6'b000010,
        MODE_TIME   = 6'b000100,
        MODE_READY  = 6'b001000,
        MODE_COOK   = 6'b010000,
        MODE_PAUSE  = 6'b100000
    } mode_t;

    // One input beat, fields from tuser and tdata
    typedef struct packed {
        logic       door_open;
        logic       pause_button;
        logic       start_button;
        logic [7:0] key_code;
        logic [1:0] action;
    } item_t;

    // One result beat, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0] entry_error;
        logic       finished;
        logic       lamp_on;
        logic [3:0] second_ones;
        logic [2:0] second_tens;
        logic [3:0] minute_ones;
        logic [2:0] minute_tens;
        logic [2:0] mode;
    } result_t;

    // mm:ss digits produced by the seconds converter
    typedef struct packed {
        logic [2:0] min_tens;
        logic [3:0] min_ones;
        logic [2:0] sec_tens;
        logic [3:0] sec_ones;
    } bcd_time_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mctc_bcd_conv.sv =====
// Seconds count to mm:ss BCD digits.
// Divide by 60 through a reciprocal multiply; tens by compare chains.
// Depends on mctc_pkg.
`default_nettype none

module mctc_bcd_conv (
    input  wire logic [10:0]          total_secs,
    output mctc_pkg::bcd_time_t       digits
);

    logic [22:0] recip_prod;
    logic [5:0]  mins;
    logic [10:0] mins_x60;
    logic [5:0]  secs;
    logic [2:0]  mins_tens;
    logic [2:0]  secs_tens;

    // Minutes and leftover seconds
    assign recip_prod = 23'(total_secs) * 23'(mctc_pkg::RECIP_60);
    assign mins       = recip_prod[22:17];
    assign mins_x60   = 11'(mins) * 11'd60;
    assign secs       = 6'(total_secs - mins_x60);

    // Minutes are at most 34, seconds at most 59
    always_comb begin
        if (mins >= 6'd30)      mins_tens = 3'd3;
        else if (mins >= 6'd20) mins_tens = 3'd2;
        else if (mins >= 6'd10) mins_tens = 3'd1;
        else                    mins_tens = 3'd0;

        if (secs >= 6'd50)      secs_tens = 3'd5;
        else if (secs >= 6'd40) secs_tens = 3'd4;
        else if (secs >= 6'd30) secs_tens = 3'd3;
        else if (secs >= 6'd20) secs_tens = 3'd2;
        else if (secs >= 6'd10) secs_tens = 3'd1;
        else                    secs_tens = 3'd0;
    end

    assign digits.min_tens = mins_tens;
    assign digits.min_ones = 4'(mins - 6'(mins_tens) * 6'd10);
    assign digits.sec_tens = secs_tens;
    assign digits.sec_ones = 4'(secs - 6'(secs_tens) * 6'd10);

endmodule

`default_nettype wire

// ===== hw/rtl/mctc_ctrl.sv =====
// Mode state machine and held mm:ss time for the cook timer.
// Takes one item per enabled cycle and gives the resulting beat.
// Depends on mctc_pkg and mctc_bcd_conv.
`default_nettype none

module mctc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step_en,
    input  wire mctc_pkg::item_t     item,
    input  wire logic [9:0]          beef_prod,
    input  wire logic [9:0]          chicken_prod,
    input  wire logic [10:0]         popcorn_secs,
    output mctc_pkg::result_t        result
);

    mctc_pkg::mode_t     mode_reg, mode_next;
    mctc_pkg::recipe_t   recipe_reg, recipe_next;
    logic [2:0]          mt_reg, mt_next;
    logic [3:0]          mo_reg, mo_next;
    logic [2:0]          st_reg, st_next;
    logic [3:0]          so_reg, so_next;
    logic [1:0]          digits_reg, digits_next;

    logic [10:0]         conv_in;
    mctc_pkg::bcd_time_t conv_out;

    logic                is_digit;
    logic                is_weight;
    logic [2:0]          sh_mt;
    logic [3:0]          sh_mo;
    logic [2:0]          sh_st;
    logic [3:0]          sh_so;
    logic                sh_valid;
    logic [2:0]          cd_mt;
    logic [3:0]          cd_mo;
    logic [2:0]          cd_st;
    logic [3:0]          cd_so;
    logic                cd_zero;
    logic                fin;
    logic [1:0]          err;
    logic [2:0]          mode_code;

    // Seconds source: popcorn time from the menu, weight product otherwise
    always_comb begin
        if (mode_reg == mctc_pkg::MODE_MENU)
            conv_in = popcorn_secs;
        else if (recipe_reg == mctc_pkg::RECIPE_BEEF)
            conv_in = 11'(beef_prod);
        else
            conv_in = 11'(chicken_prod);
    end

    mctc_bcd_conv u_conv (
        .total_secs (conv_in),
        .digits     (conv_out)
    );

    assign is_digit  = item.key_code inside {[mctc_pkg::KEY_0:mctc_pkg::KEY_9]};
    assign is_weight = item.key_code inside {[mctc_pkg::KEY_1:mctc_pkg::KEY_9]};

    // Manual entry: shift digits in from the right, tens slots saturate at 7
    assign sh_mt = (mo_reg > 4'd7) ? 3'd7 : mo_reg[2:0];
    assign sh_mo = 4'(st_reg);
    assign sh_st = (so_reg > 4'd7) ? 3'd7 : so_reg[2:0];
    assign sh_so = item.key_code[3:0];

    // Range 01:00 to 30:00 with seconds tens up to five
    always_comb begin
        sh_valid = 1'b1;
        if (sh_mt > 3'd3)
            sh_valid = 1'b0;
        if (sh_mt == 3'd0 && sh_mo == 4'd0)
            sh_valid = 1'b0;
        if (sh_mt == 3'd3 && (sh_mo != 4'd0 || sh_st != 3'd0 || sh_so != 4'd0))
            sh_valid = 1'b0;
        if (sh_st > 3'd5)
            sh_valid = 1'b0;
    end

    // One-second borrow chain; 00:00 wraps to 59:59
    always_comb begin
        cd_mt = mt_reg;
        cd_mo = mo_reg;
        cd_st = st_reg;
        cd_so = so_reg;
        if (so_reg == 4'd0) begin
            cd_so = 4'd9;
            if (st_reg == 3'd0) begin
                cd_st = 3'd5;
                if (mo_reg == 4'd0) begin
                    cd_mo = 4'd9;
                    cd_mt = (mt_reg == 3'd0) ? 3'd5 : mt_reg - 3'd1;
                end else begin
                    cd_mo = mo_reg - 4'd1;
                end
            end else begin
                cd_st = st_reg - 3'd1;
            end
        end else begin
            cd_so = so_reg - 4'd1;
        end
    end

    assign cd_zero = (cd_mt == 3'd0) && (cd_mo == 4'd0) && (cd_st == 3'd0) && (cd_so == 4'd0);

    // Mode transitions
    always_comb begin
        mode_next   = mode_reg;
        recipe_next = recipe_reg;
        mt_next     = mt_reg;
        mo_next     = mo_reg;
        st_next     = st_reg;
        so_next     = so_reg;
        digits_next = digits_reg;
        fin         = 1'b0;
        err         = mctc_pkg::ERR_NONE;
        case (mode_reg)
            mctc_pkg::MODE_MENU: begin
                if (item.action == mctc_pkg::ACT_KEY) begin
                    case (item.key_code)
                        mctc_pkg::KEY_A: begin
                            recipe_next = mctc_pkg::RECIPE_POPCORN;
                            digits_next = 2'd0;
                            mt_next     = conv_out.min_tens;
                            mo_next     = conv_out.min_ones;
                            st_next     = conv_out.sec_tens;
                            so_next     = conv_out.sec_ones;
                            mode_next   = mctc_pkg::MODE_READY;
                        end
                        mctc_pkg::KEY_B, mctc_pkg::KEY_C, mctc_pkg::KEY_D: begin
                            if (item.key_code == mctc_pkg::KEY_B)
                                recipe_next = mctc_pkg::RECIPE_BEEF;
                            else if (item.key_code == mctc_pkg::KEY_C)
                                recipe_next = mctc_pkg::RECIPE_CHICKEN;
                            else
                                recipe_next = mctc_pkg::RECIPE_MANUAL;
                            mode_next   = (item.key_code == mctc_pkg::KEY_D) ?
                                          mctc_pkg::MODE_TIME : mctc_pkg::MODE_WEIGHT;
                            digits_next = 2'd0;
                            mt_next     = 3'd0;
                            mo_next     = 4'd0;
                            st_next     = 3'd0;
                            so_next     = 4'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mctc_pkg::MODE_WEIGHT: begin
                if (item.action == mctc_pkg::ACT_KEY) begin
                    if (is_weight) begin
                        mt_next   = conv_out.min_tens;
                        mo_next   = conv_out.min_ones;
                        st_next   = conv_out.sec_tens;
                        so_next   = conv_out.sec_ones;
                        mode_next = mctc_pkg::MODE_READY;
                    end else begin
                        err = mctc_pkg::ERR_WEIGHT;
                    end
                end
            end
            mctc_pkg::MODE_TIME: begin
                if (item.action == mctc_pkg::ACT_KEY && is_digit) begin
                    mt_next     = sh_mt;
                    mo_next     = sh_mo;
                    st_next     = sh_st;
                    so_next     = sh_so;
                    digits_next = digits_reg + 2'd1;
                    // Fourth digit closes the entry
                    if (digits_reg == 2'd3) begin
                        if (sh_valid) begin
                            mode_next = mctc_pkg::MODE_READY;
                        end else begin
                            err     = mctc_pkg::ERR_RANGE;
                            mt_next = 3'd0;
                            mo_next = 4'd0;
                            st_next = 3'd0;
                            so_next = 4'd0;
                        end
                    end
                end
            end
            mctc_pkg::MODE_READY: begin
                if (item.action == mctc_pkg::ACT_POLL) begin
                    if (item.start_button && !item.door_open) begin
                        mode_next = mctc_pkg::MODE_COOK;
                    end else if (item.pause_button &&
                                 recipe_reg == mctc_pkg::RECIPE_MANUAL) begin
                        mode_next   = mctc_pkg::MODE_TIME;
                        digits_next = 2'd0;
                        mt_next     = 3'd0;
                        mo_next     = 4'd0;
                        st_next     = 3'd0;
                        so_next     = 4'd0;
                    end
                end
            end
            mctc_pkg::MODE_COOK: begin
                if (item.action == mctc_pkg::ACT_TICK) begin
                    mt_next = cd_mt;
                    mo_next = cd_mo;
                    st_next = cd_st;
                    so_next = cd_so;
                    if (cd_zero) begin
                        fin         = 1'b1;
                        digits_next = 2'd0;
                        mode_next   = mctc_pkg::MODE_MENU;
                    end else if (item.pause_button || item.door_open) begin
                        mode_next = mctc_pkg::MODE_PAUSE;
                    end
                end
            end
            mctc_pkg::MODE_PAUSE: begin
                if (item.action == mctc_pkg::ACT_POLL) begin
                    if (item.start_button && !item.door_open) begin
                        mode_next = mctc_pkg::MODE_COOK;
                    end else if (item.pause_button) begin
                        mode_next   = mctc_pkg::MODE_MENU;
                        digits_next = 2'd0;
                        mt_next     = 3'd0;
                        mo_next     = 4'd0;
                        st_next     = 3'd0;
                        so_next     = 4'd0;
                    end
                end
            end
            default: begin
                mode_next = mctc_pkg::MODE_MENU;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= mctc_pkg::MODE_MENU;
            recipe_reg <= mctc_pkg::RECIPE_POPCORN;
            mt_reg     <= 3'd0;
            mo_reg     <= 4'd0;
            st_reg     <= 3'd0;
            so_reg     <= 4'd0;
            digits_reg <= 2'd0;
        end else if (step_en) begin
            mode_reg   <= mode_next;
            recipe_reg <= recipe_next;
            mt_reg     <= mt_next;
            mo_reg     <= mo_next;
            st_reg     <= st_next;
            so_reg     <= so_next;
            digits_reg <= digits_next;
        end
    end

    // Mode number for the result beat
    always_comb begin
        case (mode_next)
            mctc_pkg::MODE_MENU:   mode_code = mctc_pkg::MODE_CODE_MENU;
            mctc_pkg::MODE_WEIGHT: mode_code = mctc_pkg::MODE_CODE_WEIGHT;
            mctc_pkg::MODE_TIME:   mode_code = mctc_pkg::MODE_CODE_TIME;
            mctc_pkg::MODE_READY:  mode_code = mctc_pkg::MODE_CODE_READY;
            mctc_pkg::MODE_COOK:   mode_code = mctc_pkg::MODE_CODE_COOK;
            mctc_pkg::MODE_PAUSE:  mode_code = mctc_pkg::MODE_CODE_PAUSE;
            default:               mode_code = mctc_pkg::MODE_CODE_MENU;
        endcase
    end

    assign result.mode        = mode_code;
    assign result.minute_tens = mt_next;
    assign result.minute_ones = mo_next;
    assign result.second_tens = st_next;
    assign result.second_ones = so_next;
    assign result.lamp_on     = (mode_next == mctc_pkg::MODE_COOK);
    assign result.finished    = fin;
    assign result.entry_error = err;

endmodule

`default_nettype wire

// ===== hw/rtl/microwave_cook_timer_controller.sv =====
// Microwave cook timer controller, top level.
// Input register, weight product stage, configuration registers, result register.
// Depends on mctc_pkg and mctc_ctrl.
//
// Usage:
//   Items arrive on the s_ stream: s_tuser carries the kind (tick, key, switch
//   poll), s_tdata the key code and the three switch bits. Every item gives
//   exactly one result beat on the m_ stream: mode, held mm:ss digits, lamp,
//   finished flag and entry error.
//   An accepted item is held in the input register, where the weight digit
//   is multiplied by both rates; once the result slot is free the controller
//   updates its state and the result register loads, raising m_tvalid. One
//   item per cycle is sustained while m_tready stays high.
//   When the receiver holds m_tready low the result register holds its beat
//   and one more item may wait in the input register; s_tready drops only
//   when both are full.
//   Reset (aresetn low, synchronous) empties both registers, returns to the
//   menu with time 00:00 and loads the rate registers with 30 s, 12 s and
//   60 s. Configuration writes on cfg_we/cfg_index/cfg_wdata take effect at
//   once and must be made while no item is in flight.
`default_nettype none

module microwave_cook_timer_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_wdata,

    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,   // key_code[7:0], start_button[8], pause_button[9],
                                        // door_open[10], zero[15:11]
    input  wire logic [1:0]  s_tuser,   // action[1:0]

    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata    // mode[2:0], minute_tens[5:3], minute_ones[9:6],
                                        // second_tens[12:10], second_ones[16:13],
                                        // lamp_on[17], finished[18], entry_error[20:19],
                                        // zero[23:21]
);

    logic [5:0]          beef_rate_reg;
    logic [5:0]          chicken_rate_reg;
    logic [10:0]         popcorn_reg;

    logic                in_valid_reg, in_valid_next;
    mctc_pkg::item_t     item_reg;
    logic [9:0]          beef_prod_reg;
    logic [9:0]          chicken_prod_reg;

    logic                out_valid_reg, out_valid_next;
    mctc_pkg::result_t   result_reg;
    mctc_pkg::result_t   result;

    logic                advance;
    logic                step;
    logic                s_accept;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beef_rate_reg    <= mctc_pkg::BEEF_RATE_RST;
            chicken_rate_reg <= mctc_pkg::CHICKEN_RATE_RST;
            popcorn_reg      <= mctc_pkg::POPCORN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                mctc_pkg::CFG_BEEF:    beef_rate_reg    <= cfg_wdata[5:0];
                mctc_pkg::CFG_CHICKEN: chicken_rate_reg <= cfg_wdata[5:0];
                mctc_pkg::CFG_POPCORN: popcorn_reg      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Handshake: the result slot frees when empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register with weight digit times both rates
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.action       <= s_tuser;
            item_reg.key_code     <= s_tdata[7:0];
            item_reg.start_button <= s_tdata[8];
            item_reg.pause_button <= s_tdata[9];
            item_reg.door_open    <= s_tdata[10];
            beef_prod_reg         <= 10'(s_tdata[3:0]) * 10'(beef_rate_reg);
            chicken_prod_reg      <= 10'(s_tdata[3:0]) * 10'(chicken_rate_reg);
        end
    end

    mctc_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step),
        .item         (item_reg),
        .beef_prod    (beef_prod_reg),
        .chicken_prod (chicken_prod_reg),
        .popcorn_secs (popcorn_reg),
        .result       (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (step)
            result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, result_reg};

    // A finished beat always lands in the menu with a cleared time
    a_fin_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result_reg.finished) |->
        (result_reg.mode == mctc_pkg::MODE_CODE_MENU && result_reg.minute_tens == 3'd0 &&
         result_reg.minute_ones == 4'd0 && result_reg.second_tens == 3'd0 &&
         result_reg.second_ones == 4'd0))
        else $error("finished beat without menu and 00:00");

    // Entry errors only occur while entering a weight or a time
    a_err_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result_reg.entry_error != mctc_pkg::ERR_NONE) |->
        (result_reg.mode == mctc_pkg::MODE_CODE_WEIGHT ||
         result_reg.mode == mctc_pkg::MODE_CODE_TIME))
        else $error("entry error outside entry modes");

    // An item held in the input register keeps its payload until it steps
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(item_reg)))
        else $error("input register lost a waiting item");

    // Lamp follows the cooking mode on every beat
    a_lamp: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (result_reg.lamp_on == (result_reg.mode == mctc_pkg::MODE_CODE_COOK)))
        else $error("lamp does not match cooking mode");

endmodule

`default_nettype wire

// ===== tb/microwave_cook_timer_controller_tb.sv =====
// Self-checking testbench for the microwave cook timer controller.
// Drives panel events on the s_ stream, predicts every display beat on the m_ stream.
// Depends on mctc_pkg and microwave_cook_timer_controller.
`default_nettype none

module microwave_cook_timer_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mctc_pkg::*;

    // Unused action code and a few keys the package does not name
    localparam logic [1:0] ACT_IDLE  = 2'd3;
    localparam logic [7:0] KEY_HASH  = 8'h23;
    localparam logic [7:0] KEY_STAR  = 8'h2A;
    localparam logic [7:0] KEY_E     = 8'h45;

    localparam int ITEMS_PER_PHASE = 166;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_LIMIT    = 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_index = CFG_BEEF;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = ACT_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    microwave_cook_timer_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Event queue feeding the driver, and displays still owed by the block
    item_t   panel_events[$];
    result_t display_due[$];

    // Oven model state and its rate registers
    logic [2:0]  oven_mode;
    recipe_t     oven_recipe;
    logic [2:0]  min_tens;
    logic [3:0]  min_ones;
    logic [2:0]  sec_tens;
    logic [3:0]  sec_ones;
    logic [2:0]  digits_in;
    logic [5:0]  beef_rate;
    logic [5:0]  chicken_rate;
    logic [10:0] popcorn_time;

    int beats_offered = 0;
    int beats_taken   = 0;
    int burst_left    = 1;
    int gap_left      = 0;
    int ready_phase   = 0;
    int ready_style   = 0;
    int stall_cycles  = 0;
    int items_queued  = 0;
    int effective_items = 0;
    int results_seen  = 0;
    int finish_count  = 0;
    int entry_err_count = 0;
    int settings_used = 1;
    int mismatch_count = 0;

    result_t mon_got;
    result_t mon_want;
    result_t acc_want;
    logic [21:0] acc_before;

    function automatic logic [21:0] state_word();
        return {oven_mode, oven_recipe, min_tens, min_ones, sec_tens, sec_ones, digits_in};
    endfunction

    function automatic void clear_time();
        min_tens = '0;
        min_ones = '0;
        sec_tens = '0;
        sec_ones = '0;
        digits_in = '0;
    endfunction

    function automatic void load_time(int total);
        int mins;
        int secs;
        mins = total / 60;
        secs = total % 60;
        min_tens = 3'((mins / 10) & 7);
        min_ones = 4'(mins % 10);
        sec_tens = 3'(secs / 10);
        sec_ones = 4'(secs % 10);
    endfunction

    // Advance the oven by one panel event and return the display it shows
    function automatic result_t predict_display(input item_t ev);
        result_t    r;
        logic       fin;
        logic [1:0] err;
        logic [5:0] rate;
        fin = 1'b0;
        err = ERR_NONE;
        case (oven_mode)
            MODE_CODE_MENU: begin
                if (ev.action == ACT_KEY) begin
                    if (ev.key_code == KEY_A) begin
                        oven_recipe = RECIPE_POPCORN;
                        clear_time();
                        load_time(int'(popcorn_time));
                        oven_mode = MODE_CODE_READY;
                    end else if (ev.key_code == KEY_B || ev.key_code == KEY_C) begin
                        oven_recipe = (ev.key_code == KEY_B) ? RECIPE_BEEF : RECIPE_CHICKEN;
                        clear_time();
                        oven_mode = MODE_CODE_WEIGHT;
                    end else if (ev.key_code == KEY_D) begin
                        oven_recipe = RECIPE_MANUAL;
                        clear_time();
                        oven_mode = MODE_CODE_TIME;
                    end
                end
            end
            MODE_CODE_WEIGHT: begin
                if (ev.action == ACT_KEY) begin
                    if (ev.key_code >= KEY_1 && ev.key_code <= KEY_9) begin
                        rate = (oven_recipe == RECIPE_BEEF) ? beef_rate : chicken_rate;
                        load_time(int'(ev.key_code - KEY_0) * int'(rate));
                        oven_mode = MODE_CODE_READY;
                    end else begin
                        err = ERR_WEIGHT;
                    end
                end
            end
            MODE_CODE_TIME: begin
                // digits shift in from the right; tens slots saturate at 7
                if (ev.action == ACT_KEY && ev.key_code >= KEY_0 && ev.key_code <= KEY_9) begin
                    min_tens = (min_ones > 4'd7) ? 3'd7 : min_ones[2:0];
                    min_ones = {1'b0, sec_tens};
                    sec_tens = (sec_ones > 4'd7) ? 3'd7 : sec_ones[2:0];
                    sec_ones = 4'(ev.key_code - KEY_0);
                    digits_in = digits_in + 3'd1;
                    if (digits_in >= 3'd4) begin
                        digits_in = '0;
                        if (min_tens > 3'd3 || (min_tens == 3'd0 && min_ones < 4'd1) ||
                            (min_tens == 3'd3 &&
                             (min_ones != 4'd0 || sec_tens != 3'd0 || sec_ones != 4'd0)) ||
                            sec_tens > 3'd5) begin
                            err = ERR_RANGE;
                            clear_time();
                        end else begin
                            oven_mode = MODE_CODE_READY;
                        end
                    end
                end
            end
            MODE_CODE_READY: begin
                if (ev.action == ACT_POLL) begin
                    if (ev.start_button && !ev.door_open) begin
                        oven_mode = MODE_CODE_COOK;
                    end else if (ev.pause_button && oven_recipe == RECIPE_MANUAL) begin
                        clear_time();
                        oven_mode = MODE_CODE_TIME;
                    end
                end
            end
            MODE_CODE_COOK: begin
                if (ev.action == ACT_TICK) begin
                    // BCD borrow chain, 00:00 wraps to 59:59
                    if (sec_ones == 4'd0) begin
                        sec_ones = 4'd9;
                        if (sec_tens == 3'd0) begin
                            sec_tens = 3'd5;
                            if (min_ones == 4'd0) begin
                                min_ones = 4'd9;
                                min_tens = (min_tens == 3'd0) ? 3'd5 : min_tens - 3'd1;
                            end else begin
                                min_ones = min_ones - 4'd1;
                            end
                        end else begin
                            sec_tens = sec_tens - 3'd1;
                        end
                    end else begin
                        sec_ones = sec_ones - 4'd1;
                    end
                    if ({min_tens, min_ones, sec_tens, sec_ones} == '0) begin
                        fin = 1'b1;
                        clear_time();
                        oven_mode = MODE_CODE_MENU;
                    end else if (ev.pause_button || ev.door_open) begin
                        oven_mode = MODE_CODE_PAUSE;
                    end
                end
            end
            MODE_CODE_PAUSE: begin
                if (ev.action == ACT_POLL) begin
                    if (ev.start_button && !ev.door_open) begin
                        oven_mode = MODE_CODE_COOK;
                    end else if (ev.pause_button) begin
                        clear_time();
                        oven_mode = MODE_CODE_MENU;
                    end
                end
            end
            default: begin
                oven_mode = MODE_CODE_MENU;
            end
        endcase
        r.mode        = oven_mode;
        r.minute_tens = min_tens;
        r.minute_ones = min_ones;
        r.second_tens = sec_tens;
        r.second_ones = sec_ones;
        r.lamp_on     = (oven_mode == MODE_CODE_COOK);
        r.finished    = fin;
        r.entry_error = err;
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned seen);
        if (want != seen) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $error("%s: expected %0d, got %0d", field, want, seen);
        end
    endfunction

    task automatic push_item(logic [1:0] act, logic [7:0] key, logic st, logic pa, logic dr);
        item_t ev;
        ev.action       = act;
        ev.key_code     = key;
        ev.start_button = st;
        ev.pause_button = pa;
        ev.door_open    = dr;
        panel_events.push_back(ev);
        items_queued++;
    endtask

    // A valid manual time between 01:00 and 30:00, now and then with a stray key
    task automatic push_manual_time();
        int m;
        int s;
        m = $urandom_range(1, 30);
        s = (m == 30) ? 0 : $urandom_range(0, 59);
        if ($urandom_range(0, 5) == 0)
            push_item(ACT_KEY, ($urandom_range(0, 1) != 0) ? KEY_HASH : KEY_A,
                      1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_0 + 8'(m / 10), 1'($urandom), 1'($urandom), 1'($urandom));
        push_item(ACT_KEY, KEY_0 + 8'(m % 10), 1'($urandom), 1'($urandom), 1'($urandom));
        push_item(ACT_KEY, KEY_0 + 8'(s / 10), 1'($urandom), 1'($urandom), 1'($urandom));
        push_item(ACT_KEY, KEY_0 + 8'(s % 10), 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // One cooking session from the menu: choose, enter, start, count, pause, cancel; or a short run of noise items
    task automatic gen_session();
        int pick;
        int n;
        logic [7:0] menu_key;
        logic [7:0] bad_key;
        logic dr;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            // noise: anything the fields allow
            n = $urandom_range(1, 8);
            repeat (n)
                push_item(2'($urandom_range(0, 3)), 8'($urandom),
                          1'($urandom), 1'($urandom), 1'($urandom));
        end else begin
            menu_key = KEY_A + 8'($urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0)
                push_item(ACT_POLL, 8'($urandom), 1'b1, 1'b0, 1'b0);
            push_item(ACT_KEY, menu_key, 1'($urandom), 1'($urandom), 1'($urandom));
            if (menu_key == KEY_B || menu_key == KEY_C) begin
                if ($urandom_range(0, 3) == 0) begin
                    do bad_key = 8'($urandom); while (bad_key >= KEY_1 && bad_key <= KEY_9);
                    push_item(ACT_KEY, bad_key, 1'b0, 1'b0, 1'b0);
                end
                push_item(ACT_KEY, KEY_1 + 8'($urandom_range(0, 8)), 1'b0, 1'b0, 1'b0);
            end else if (menu_key == KEY_D) begin
                if ($urandom_range(0, 4) == 0)
                    repeat (4) push_item(ACT_KEY, KEY_0 + 8'($urandom_range(0, 9)),
                                         1'b0, 1'b0, 1'b0);
                push_manual_time();
            end
            // ready: door-open start, manual re-entry, then a real start
            if ($urandom_range(0, 3) == 0)
                push_item(ACT_POLL, 8'($urandom), 1'b1, 1'($urandom), 1'b1);
            if (menu_key == KEY_D && $urandom_range(0, 5) == 0) begin
                push_item(ACT_POLL, 8'($urandom), 1'b0, 1'b1, 1'b0);
                push_manual_time();
            end
            push_item(ACT_POLL, 8'($urandom), 1'b1, 1'($urandom), 1'b0);
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                pick = $urandom_range(0, 29);
                if (pick == 0) begin
                    dr = 1'($urandom);
                    push_item(ACT_TICK, 8'($urandom), 1'($urandom), dr ? 1'($urandom) : 1'b1, dr);
                    if ($urandom_range(0, 2) == 0) begin
                        push_item(ACT_POLL, 8'($urandom), 1'b0, 1'b1, 1'($urandom));
                        break;
                    end
                    push_item(ACT_POLL, 8'($urandom), 1'b1, 1'($urandom), 1'b0);
                end else if (pick == 1) begin
                    push_item(ACT_POLL, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
                end else begin
                    push_item(ACT_TICK, 8'($urandom), 1'($urandom), 1'b0, 1'b0);
                end
            end
            // leave the session in the menu if it has not finished
            push_item(ACT_TICK, 8'($urandom), 1'b0, 1'b1, 1'b0);
            push_item(ACT_POLL, 8'($urandom), 1'b0, 1'b1, 1'b0);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_BEEF:    beef_rate    = val[5:0];
            CFG_CHICKEN: chicken_rate = val[5:0];
            CFG_POPCORN: popcorn_time = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (panel_events.size() != 0 || display_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(int goal);
        int start_count;
        start_count = items_queued;
        while (items_queued - start_count < goal) begin
            if (panel_events.size() < 8)
                gen_session();
            else
                @(negedge aclk);
        end
        drain();
    endtask

    // Driver: bursts of beats separated by random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || beats_taken == beats_offered) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (panel_events.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tuser  <= panel_events[0].action;
                s_tdata  <= {5'b0, panel_events[0].door_open, panel_events[0].pause_button,
                             panel_events[0].start_button, panel_events[0].key_code};
                beats_offered = beats_offered + 1;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Accepted input beat: predict the display it must produce
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            acc_before = state_word();
            acc_want = predict_display(panel_events.pop_front());
            display_due.push_back(acc_want);
            if (acc_before != state_word() || acc_want.entry_error != ERR_NONE)
                effective_items++;
            if (acc_want.finished)
                finish_count++;
            if (acc_want.entry_error != ERR_NONE)
                entry_err_count++;
            beats_taken <= beats_taken + 1;
        end
    end

    // Receiver back-pressure: the style is picked anew whenever its random phase counter runs out
    always @(negedge aclk) begin
        if (ready_phase == 0) begin
            ready_style = $urandom_range(0, 3);
            ready_phase = $urandom_range(20, 120);
        end else begin
            ready_phase = ready_phase - 1;
        end
        case (ready_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2: m_tready <= (ready_phase % 3 == 0);
            default: m_tready <= ((ready_phase % 16) >= 4);
        endcase
    end

    // Monitor: compare each display beat with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_got = m_tdata[$bits(result_t)-1:0];
            results_seen++;
            if (display_due.size() == 0) begin
                mismatch_count++;
                $error("display beat with no event outstanding");
            end else begin
                mon_want = display_due.pop_front();
                check_field("mode",        mon_want.mode,        mon_got.mode);
                check_field("minute_tens", mon_want.minute_tens, mon_got.minute_tens);
                check_field("minute_ones", mon_want.minute_ones, mon_got.minute_ones);
                check_field("second_tens", mon_want.second_tens, mon_got.second_tens);
                check_field("second_ones", mon_want.second_ones, mon_got.second_ones);
                check_field("lamp_on",     mon_want.lamp_on,     mon_got.lamp_on);
                check_field("finished",    mon_want.finished,    mon_got.finished);
                check_field("entry_error", mon_want.entry_error, mon_got.entry_error);
            end
        end
    end

    // Watchdog: too long without any beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sequencer: reset, directed events, then random sessions under several settings
    initial begin
        oven_mode    = MODE_CODE_MENU;
        oven_recipe  = RECIPE_POPCORN;
        clear_time();
        beef_rate    = BEEF_RATE_RST;
        chicken_rate = CHICKEN_RATE_RST;
        popcorn_time = POPCORN_RST;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // unused action, stray events in the menu, unknown menu key
        push_item(ACT_IDLE, KEY_A, 1'b1, 1'b1, 1'b1);
        push_item(ACT_TICK, KEY_9, 1'b1, 1'b1, 1'b1);
        push_item(ACT_POLL, 8'hFF, 1'b1, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_E, 1'b0, 1'b0, 1'b0);
        // beef: bad keys, then nine units
        push_item(ACT_KEY, KEY_B, 1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_STAR, 1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_0, 1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_9, 1'b0, 1'b0, 1'b0);
        // ready: pause ignored outside manual, door open blocks start
        push_item(ACT_POLL, 8'h00, 1'b0, 1'b1, 1'b0);
        push_item(ACT_POLL, 8'h00, 1'b1, 1'b0, 1'b1);
        push_item(ACT_POLL, 8'h00, 1'b1, 1'b0, 1'b0);
        // cook one second, door opens, cancel
        push_item(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
        push_item(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b1);
        push_item(ACT_POLL, 8'h00, 1'b0, 1'b1, 1'b1);
        // manual: non-digit ignored, 30:01 rejected, 30:00 taken, pause re-enters
        push_item(ACT_KEY, KEY_D, 1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_HASH, 1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_0 + 8'd3, 1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_0, 1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_0, 1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_1, 1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_0 + 8'd3, 1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_0, 1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_0, 1'b0, 1'b0, 1'b0);
        push_item(ACT_KEY, KEY_0, 1'b0, 1'b0, 1'b0);
        push_item(ACT_POLL, 8'h00, 1'b0, 1'b1, 1'b0);
        drain();

        run_phase(ITEMS_PER_PHASE);
        for (int phase = 1; phase <= 6; phase++) begin
            case (phase)
                1: begin
                    write_reg(CFG_BEEF, 11'd1);
                    write_reg(CFG_CHICKEN, 11'd1);
                    write_reg(CFG_POPCORN, 11'd1);
                end
                2: begin
                    write_reg(CFG_BEEF, 11'd60);
                    write_reg(CFG_CHICKEN, 11'd60);
                    write_reg(CFG_POPCORN, 11'd1800);
                end
                3: begin
                    // full field values: zero chicken rate, popcorn past 30:00
                    write_reg(CFG_BEEF, 11'd63);
                    write_reg(CFG_CHICKEN, 11'd0);
                    write_reg(CFG_POPCORN, 11'd2047);
                end
                4: begin
                    // zero times count down from 59:59
                    write_reg(CFG_BEEF, 11'd0);
                    write_reg(CFG_CHICKEN, 11'd63);
                    write_reg(CFG_POPCORN, 11'd0);
                end
                default: begin
                    write_reg(CFG_BEEF, 11'($urandom_range(1, 60)));
                    write_reg(CFG_CHICKEN, 11'($urandom_range(1, 60)));
                    write_reg(CFG_POPCORN, ($urandom_range(0, 3) == 0) ?
                              11'($urandom_range(1, 1800)) : 11'($urandom_range(1, 240)));
                end
            endcase
            settings_used++;
            run_phase(ITEMS_PER_PHASE);
        end
        drain();

        if (display_due.size() != 0) begin
            mismatch_count++;
            $error("%0d display beats never arrived", display_due.size());
        end
        $display("covered %0d panel events that changed state, %0d display beats checked",
                 effective_items, results_seen);
        $display("across %0d rate settings: %0d finished countdowns, %0d entry errors",
                 settings_used, finish_count, entry_err_count);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== microwave_cook_timer_controller.f =====
hw/rtl/mctc_pkg.sv
hw/rtl/mctc_bcd_conv.sv
hw/rtl/mctc_ctrl.sv
hw/rtl/microwave_cook_timer_controller.sv
tb/microwave_cook_timer_controller_tb.sv
